// ----- src/brs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

    localparam int NUM_BINS = 16;

    localparam int CMD_W = 3;
    localparam int BIN_W = 4;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;
    localparam int POP_W = 16;
    localparam int SUM_W = 64;
    localparam int CNT_W = 32;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_WR_BOUND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECOMP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SELECT   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_UDF  = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd3;

    // pair count form fed to the term multiplier
    localparam logic [1:0] CNT_PAIR = 2'd0;
    localparam logic [1:0] CNT_SELF = 2'd1;
    localparam logic [1:0] CNT_ONE  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic       accept;
        logic       ram_wr;
        logic       ram_swap;
        logic       ram_rd;
        logic       pop_set;
        logic       pop_inc;
        logic       pop_dec;
        logic       pop_rd_j;
        logic       popi_ld;
        logic       cnt_ld;
        logic [1:0] cnt_mode;
        logic       term_ld;
        logic       mul_lo;
        logic       mul_hi;
        logic       rem_fix;
        logic       rem_sub_row;
        logic       rem_sub_term;
        logic       i_clr;
        logic       i_inc;
        logic       i_from_j;
        logic       j_clr;
        logic       j_inc;
        logic       j_dec;
        logic       j_last_ld;
        logic       acc_clr;
        logic       acc_add;
        logic       acc_add_sat;
        logic       tot_acc;
        logic       tot_fin;
        logic       row_wr_sum;
        logic       row_wr_zero;
        logic       row_adj;
        logic       grow;
        logic       res_pick;
        logic       st_set;
        logic [1:0] st_code;
        logic       out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic a_tbl;
        logic b_tbl;
        logic a_use;
        logic pop_full;
        logic pop_empty;
        logic total_zero;
        logic j_eq_i;
        logic j_lt_i;
        logic j_last;
        logic j_zero;
        logic i_use;
        logic i_last;
        logic r_lt_row;
        logic r_lt_term;
    } t_dp_sts;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        return (b > a) ? '0 : a - b;
    endfunction

endpackage

`default_nettype wire

// ----- src/brs_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface brs_req_if;
    logic                        valid;
    logic                        ready;
    logic [brs_pkg::CMD_W-1:0]   command;
    logic [brs_pkg::BIN_W-1:0]   bin_a;
    logic [brs_pkg::BIN_W-1:0]   bin_b;
    logic [brs_pkg::VAL_W-1:0]   value;

    modport source (output valid, command, bin_a, bin_b, value, input ready);
    modport sink   (input valid, command, bin_a, bin_b, value, output ready);
endinterface

`default_nettype wire

// ----- src/brs_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface brs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [brs_pkg::BIN_W-1:0]   first_bin;
    logic [brs_pkg::BIN_W-1:0]   second_bin;
    logic [brs_pkg::SUM_W-1:0]   total_rate;
    logic [brs_pkg::ST_W-1:0]    status;

    modport source (output valid, first_bin, second_bin, total_rate, status, input ready);
    modport sink   (input valid, first_bin, second_bin, total_rate, status, output ready);
endinterface

`default_nettype wire

// ----- src/binned_pair_rate_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pair-rate table for a binned coagulation sampler.
// Channels: i_req carries one request (command, bin_a, bin_b, value); o_rsp
// returns one result per request (first_bin, second_bin, total_rate, status).
// i_cfg_we / i_cfg_data write active_bins; write it only while idle.
// Every kernel-bound times pair-count term runs through one shared 32x32
// multiplier in these steps: bound RAM read, count multiply, bound multiply,
// accumulate.
// One request is worked at a time; the next is taken as soon as the previous
// result sits in the output register, even if the receiver has not taken it.
// A stalled receiver holds the result; the block then waits in its last state.
// Reset (synchronous, active low) clears populations, row sums, the total and
// sets active_bins to 16. The bound table is not cleared: write every bound
// before it is used.
module binned_pair_rate_sampler (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    brs_req_if.sink                        i_req,
    brs_rsp_if.source                      o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [brs_pkg::CFG_W-1:0] i_cfg_data
);
    import brs_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: decodes the request and steps the term walk
    brs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_command   (i_req.command),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // tables, multiplier, row sums and result register
    brs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_bin_a      (i_req.bin_a),
        .i_bin_b      (i_req.bin_b),
        .i_value      (i_req.value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_first_bin  (o_rsp.first_bin),
        .o_second_bin (o_rsp.second_bin),
        .o_total_rate (o_rsp.total_rate),
        .o_status     (o_rsp.status)
    );
endmodule

`default_nettype wire

// ----- src/brs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ----- src/brs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brs_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [brs_pkg::CMD_W-1:0] i_command,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output brs_pkg::t_dp_cmd               o_cmd,
    input  wire brs_pkg::t_dp_sts          i_sts
);
    import brs_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_WR2     = 5'd2;
    localparam logic [4:0] S_RC_CHK  = 5'd3;
    localparam logic [4:0] S_T0      = 5'd4;
    localparam logic [4:0] S_T1      = 5'd5;
    localparam logic [4:0] S_T2      = 5'd6;
    localparam logic [4:0] S_RC_USE  = 5'd7;
    localparam logic [4:0] S_AD_USE  = 5'd8;
    localparam logic [4:0] S_SEL_MLO = 5'd9;
    localparam logic [4:0] S_SEL_MHI = 5'd10;
    localparam logic [4:0] S_SEL_FIX = 5'd11;
    localparam logic [4:0] S_SEL_ROW = 5'd12;
    localparam logic [4:0] S_SEL_COL = 5'd13;
    localparam logic [4:0] S_SEL_USE = 5'd14;
    localparam logic [4:0] S_TOT     = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    logic [4:0]       r_state, n_state;
    logic [CMD_W-1:0] r_op;
    logic             r_out_valid;
    t_dp_cmd          cmd;

    always_comb begin
        cmd        = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_op)
                    CMD_WR_BOUND: begin
                        if (i_sts.a_tbl && i_sts.b_tbl) begin
                            cmd.ram_wr = 1'b1;
                            n_state    = S_WR2;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_SET_POP: begin
                        cmd.pop_set = i_sts.a_tbl;
                        n_state     = S_DONE;
                    end
                    CMD_RECOMP: begin
                        cmd.i_clr   = 1'b1;
                        cmd.j_clr   = 1'b1;
                        cmd.acc_clr = 1'b1;
                        n_state     = S_RC_CHK;
                    end
                    CMD_ADD: begin
                        if (!i_sts.a_use) begin
                            n_state = S_DONE;
                        end else if (i_sts.pop_full) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_OVF;
                            n_state     = S_DONE;
                        end else begin
                            cmd.j_clr   = 1'b1;
                            cmd.acc_clr = 1'b1;
                            n_state     = S_T0;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!i_sts.a_use) begin
                            n_state = S_DONE;
                        end else if (i_sts.pop_empty) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_UDF;
                            n_state     = S_DONE;
                        end else begin
                            // decrement first: terms then use the new count
                            cmd.pop_dec = 1'b1;
                            cmd.j_clr   = 1'b1;
                            cmd.acc_clr = 1'b1;
                            n_state     = S_T0;
                        end
                    end
                    CMD_SELECT: begin
                        if (i_sts.total_zero) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_ZERO;
                            n_state     = S_DONE;
                        end else begin
                            n_state = S_SEL_MLO;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WR2: begin
                cmd.ram_wr   = 1'b1;
                cmd.ram_swap = 1'b1;
                n_state      = S_DONE;
            end
            S_RC_CHK: begin
                if (i_sts.i_use) begin
                    n_state = S_T0;
                end else begin
                    cmd.row_wr_zero = 1'b1;
                    cmd.j_clr       = 1'b1;
                    cmd.acc_clr     = 1'b1;
                    if (i_sts.i_last) begin
                        n_state = S_TOT;
                    end else begin
                        cmd.i_inc = 1'b1;
                        n_state   = S_RC_CHK;
                    end
                end
            end
            S_T0: begin
                cmd.ram_rd  = 1'b1;
                cmd.popi_ld = 1'b1;
                n_state     = S_T1;
            end
            S_T1: begin
                cmd.cnt_ld   = 1'b1;
                cmd.pop_rd_j = 1'b1;
                if (r_op == CMD_RECOMP) begin
                    cmd.cnt_mode = i_sts.j_eq_i ? CNT_SELF : CNT_PAIR;
                end else if (r_op == CMD_SELECT) begin
                    cmd.cnt_mode = CNT_PAIR;
                end else begin
                    cmd.cnt_mode = CNT_ONE;
                end
                n_state = S_T2;
            end
            S_T2: begin
                cmd.term_ld = 1'b1;
                if (r_op == CMD_RECOMP) begin
                    n_state = S_RC_USE;
                end else if (r_op == CMD_SELECT) begin
                    n_state = S_SEL_USE;
                end else begin
                    n_state = S_AD_USE;
                end
            end
            S_RC_USE: begin
                if (i_sts.j_eq_i) begin
                    cmd.row_wr_sum = 1'b1;
                    cmd.j_clr      = 1'b1;
                    cmd.acc_clr    = 1'b1;
                    if (i_sts.i_last) begin
                        n_state = S_TOT;
                    end else begin
                        cmd.i_inc = 1'b1;
                        n_state   = S_RC_CHK;
                    end
                end else begin
                    cmd.acc_add_sat = 1'b1;
                    cmd.j_inc       = 1'b1;
                    n_state         = S_T0;
                end
            end
            S_AD_USE: begin
                if (i_sts.j_lt_i) begin
                    cmd.acc_add = 1'b1;
                    cmd.j_inc   = 1'b1;
                    n_state     = S_T0;
                end else begin
                    cmd.row_adj = 1'b1;
                    cmd.grow    = (r_op == CMD_ADD);
                    if (i_sts.j_last) begin
                        cmd.pop_inc = (r_op == CMD_ADD);
                        cmd.j_clr   = 1'b1;
                        cmd.acc_clr = 1'b1;
                        n_state     = S_TOT;
                    end else begin
                        cmd.j_inc = 1'b1;
                        n_state   = S_T0;
                    end
                end
            end
            S_SEL_MLO: begin
                cmd.mul_lo = 1'b1;
                n_state    = S_SEL_MHI;
            end
            S_SEL_MHI: begin
                cmd.mul_hi = 1'b1;
                n_state    = S_SEL_FIX;
            end
            S_SEL_FIX: begin
                cmd.rem_fix   = 1'b1;
                cmd.j_last_ld = 1'b1;
                n_state       = S_SEL_ROW;
            end
            S_SEL_ROW: begin
                if (i_sts.j_zero || i_sts.r_lt_row) begin
                    cmd.i_from_j = 1'b1;
                    cmd.j_clr    = 1'b1;
                    n_state      = S_SEL_COL;
                end else begin
                    cmd.rem_sub_row = 1'b1;
                    cmd.j_dec       = 1'b1;
                end
            end
            S_SEL_COL: begin
                if (i_sts.j_eq_i) begin
                    cmd.res_pick = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_T0;
                end
            end
            S_SEL_USE: begin
                if (i_sts.r_lt_term) begin
                    cmd.res_pick = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    cmd.rem_sub_term = 1'b1;
                    cmd.j_inc        = 1'b1;
                    n_state          = S_SEL_COL;
                end
            end
            S_TOT: begin
                if (i_sts.j_last) begin
                    cmd.tot_fin = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    cmd.tot_acc = 1'b1;
                    cmd.j_inc   = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= CMD_WR_BOUND;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.accept) begin
                r_op <= i_command;
            end
            if (cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted request did not reach decode");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_term_t1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T1) |-> $past(r_state == S_T0))
        else $error("term stage 1 without read stage");

    a_term_t2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T2) |-> $past(r_state == S_T1))
        else $error("term stage 2 without count stage");
endmodule

`default_nettype wire

// ----- src/brs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brs_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire brs_pkg::t_dp_cmd          i_cmd,
    output brs_pkg::t_dp_sts               o_sts,
    input  wire logic [brs_pkg::BIN_W-1:0] i_bin_a,
    input  wire logic [brs_pkg::BIN_W-1:0] i_bin_b,
    input  wire logic [brs_pkg::VAL_W-1:0] i_value,
    input  wire logic                      i_cfg_we,
    input  wire logic [brs_pkg::CFG_W-1:0] i_cfg_data,
    output logic      [brs_pkg::BIN_W-1:0] o_first_bin,
    output logic      [brs_pkg::BIN_W-1:0] o_second_bin,
    output logic      [brs_pkg::SUM_W-1:0] o_total_rate,
    output logic      [brs_pkg::ST_W-1:0]  o_status
);
    import brs_pkg::*;

    localparam int IW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NW    = $clog2(NUM_BINS + 1);
    localparam int DEPTH = NUM_BINS * NUM_BINS;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0] r_active_bins;
    logic [BIN_W-1:0] r_a, r_b;
    logic [VAL_W-1:0] r_v;
    logic [IW-1:0]    r_i, r_j, r_first, r_second;
    logic [POP_W-1:0] r_popi;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_term, r_acc, r_rem, r_total;
    logic [POP_W-1:0] r_pop [NUM_BINS];
    logic [SUM_W-1:0] r_row [NUM_BINS];
    logic [ST_W-1:0]  r_status;
    logic [BIN_W-1:0] r_o_first, r_o_second;
    logic [SUM_W-1:0] r_o_total;
    logic [ST_W-1:0]  r_o_status;

    logic [NW-1:0]    n_eff;
    logic [POP_W-1:0] pop_rd;
    logic [SUM_W-1:0] row_rd;
    logic [VAL_W-1:0] bnd;
    logic [AW-1:0]    addr_ij, addr_ji;
    logic [POP_W-1:0] cnt_b;
    logic [CNT_W-1:0] cnt_p, cnt_val;
    logic [VAL_W-1:0] mul_a, mul_b;
    logic [SUM_W-1:0] mul_p;
    logic [SUM_W-1:0] acc_term, acc_term_sat, delta, row_new, tot_sum;

    // effective bin count, saturated into 1..NUM_BINS
    always_comb begin
        if (r_active_bins == '0) begin
            n_eff = NW'(1);
        end else if (8'(r_active_bins) > 8'(NUM_BINS)) begin
            n_eff = NW'(NUM_BINS);
        end else begin
            n_eff = NW'(r_active_bins);
        end
    end

    assign pop_rd  = r_pop[i_cmd.pop_rd_j ? r_j : r_i];
    assign row_rd  = r_row[r_j];
    assign addr_ij = AW'(r_i) * AW'(NUM_BINS) + AW'(r_j);
    assign addr_ji = AW'(r_j) * AW'(NUM_BINS) + AW'(r_i);

    brs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_bound (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_wr),
        .i_waddr (i_cmd.ram_swap ? addr_ji : addr_ij),
        .i_wdata (r_v),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (addr_ij),
        .o_rdata (bnd)
    );

    // pair count: pi*pj, pi*(pi-1)/2 or pj alone
    assign cnt_b = (i_cmd.cnt_mode == CNT_SELF) ? (r_popi - POP_W'(1)) : pop_rd;
    assign cnt_p = r_popi * cnt_b;
    always_comb begin
        unique case (i_cmd.cnt_mode)
            CNT_SELF: cnt_val = cnt_p >> 1;
            CNT_ONE:  cnt_val = {{(CNT_W-POP_W){1'b0}}, pop_rd};
            default:  cnt_val = cnt_p;
        endcase
    end

    // shared 32x32 multiplier: bound x count, or total halves x fraction
    assign mul_a = i_cmd.mul_lo ? r_total[31:0] :
                   i_cmd.mul_hi ? r_total[63:32] : bnd;
    assign mul_b = (i_cmd.mul_lo || i_cmd.mul_hi) ? r_v : r_cnt;
    assign mul_p = mul_a * mul_b;

    assign acc_term     = r_acc + r_term;
    assign acc_term_sat = sat_add(r_acc, r_term);
    assign delta        = (r_j == r_i) ? acc_term : r_term;
    assign row_new      = i_cmd.grow ? sat_add(row_rd, delta) : sat_sub(row_rd, delta);
    assign tot_sum      = sat_add(r_acc, row_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bins <= CFG_RESET;
            r_total       <= '0;
            for (int k = 0; k < NUM_BINS; k++) begin
                r_pop[k] <= '0;
                r_row[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active_bins <= i_cfg_data;
            end
            if (i_cmd.tot_fin) begin
                r_total <= tot_sum;
            end
            if (i_cmd.pop_set) begin
                r_pop[r_i] <= r_v[POP_W-1:0];
            end else if (i_cmd.pop_inc) begin
                r_pop[r_i] <= r_pop[r_i] + POP_W'(1);
            end else if (i_cmd.pop_dec) begin
                r_pop[r_i] <= r_pop[r_i] - POP_W'(1);
            end
            if (i_cmd.row_wr_sum) begin
                r_row[r_i] <= acc_term_sat;
            end else if (i_cmd.row_wr_zero) begin
                r_row[r_i] <= '0;
            end else if (i_cmd.row_adj) begin
                r_row[r_j] <= row_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a      <= i_bin_a;
            r_b      <= i_bin_b;
            r_v      <= i_value;
            r_status <= ST_OK;
            r_first  <= '0;
            r_second <= '0;
        end
        if (i_cmd.accept) begin
            r_i <= IW'(i_bin_a);
        end else if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + IW'(1);
        end else if (i_cmd.i_from_j) begin
            r_i <= r_j;
        end
        if (i_cmd.accept) begin
            r_j <= IW'(i_bin_b);
        end else if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + IW'(1);
        end else if (i_cmd.j_dec) begin
            r_j <= r_j - IW'(1);
        end else if (i_cmd.j_last_ld) begin
            r_j <= IW'(n_eff - NW'(1));
        end
        if (i_cmd.popi_ld) begin
            r_popi <= pop_rd;
        end
        if (i_cmd.cnt_ld) begin
            r_cnt <= cnt_val;
        end
        if (i_cmd.term_ld || i_cmd.mul_lo) begin
            r_term <= mul_p;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add_sat) begin
            r_acc <= acc_term_sat;
        end else if (i_cmd.acc_add) begin
            r_acc <= acc_term;
        end else if (i_cmd.tot_acc) begin
            r_acc <= tot_sum;
        end
        // remaining target of the pair pick
        if (i_cmd.mul_hi) begin
            r_rem <= mul_p;
        end else if (i_cmd.rem_fix) begin
            r_rem <= r_rem + {32'b0, r_term[63:32]};
        end else if (i_cmd.rem_sub_row) begin
            r_rem <= r_rem - row_rd;
        end else if (i_cmd.rem_sub_term) begin
            r_rem <= r_rem - r_term;
        end
        if (i_cmd.st_set) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.res_pick) begin
            r_first  <= r_i;
            r_second <= r_j;
        end
        if (i_cmd.out_ld) begin
            r_o_first  <= BIN_W'(r_first);
            r_o_second <= BIN_W'(r_second);
            r_o_total  <= r_total;
            r_o_status <= r_status;
        end
    end

    assign o_sts.a_tbl      = 8'(r_a) < 8'(NUM_BINS);
    assign o_sts.b_tbl      = 8'(r_b) < 8'(NUM_BINS);
    assign o_sts.a_use      = 8'(r_a) < 8'(n_eff);
    assign o_sts.pop_full   = (pop_rd == '1);
    assign o_sts.pop_empty  = (pop_rd == '0);
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.j_eq_i     = (r_j == r_i);
    assign o_sts.j_lt_i     = (r_j < r_i);
    assign o_sts.j_last     = ((NW'(r_j) + NW'(1)) == n_eff);
    assign o_sts.j_zero     = (r_j == '0);
    assign o_sts.i_use      = (NW'(r_i) < n_eff);
    assign o_sts.i_last     = (r_i == IW'(NUM_BINS - 1));
    assign o_sts.r_lt_row   = (r_rem < row_rd);
    assign o_sts.r_lt_term  = (r_rem < r_term);

    assign o_first_bin  = r_o_first;
    assign o_second_bin = r_o_second;
    assign o_total_rate = r_o_total;
    assign o_status     = r_o_status;
endmodule

`default_nettype wire

// ----- test/binned_pair_rate_sampler_tb.sv -----
`timescale 1ns / 1ps

module binned_pair_rate_sampler_tb;
    import brs_pkg::*;

    localparam int NBINS = NUM_BINS;
    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [BIN_W-1:0] first_bin;
        logic [BIN_W-1:0] second_bin;
        logic [SUM_W-1:0] total_rate;
        logic [ST_W-1:0]  status;
    } t_rate_rsp;

    // one directed request; typed = expected result written in the row
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [BIN_W-1:0] a;
        logic [BIN_W-1:0] b;
        logic [VAL_W-1:0] val;
        logic             typed;
        t_rate_rsp        rsp;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    brs_req_if req_if ();
    brs_rsp_if rsp_if ();

    binned_pair_rate_sampler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic [VAL_W-1:0] bound_q [NBINS][NBINS];
    logic [POP_W-1:0] pop_q [NBINS];
    logic [SUM_W-1:0] row_q [NBINS];
    logic [SUM_W-1:0] total_q;
    logic [CFG_W-1:0] bins_cfg;

    t_rate_rsp pending_rsp [$];
    int        err_cnt = 0;
    bit        calm = 1'b0;   // no idling on either side while set

    function automatic int bins_in_use();
        if (bins_cfg < 1) return 1;
        if (bins_cfg > NBINS) return NBINS;
        return int'(bins_cfg);
    endfunction

    function automatic logic [SUM_W-1:0] clamp_add(logic [SUM_W-1:0] x, logic [SUM_W-1:0] y);
        logic [SUM_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] floor_sub(logic [SUM_W-1:0] x, logic [SUM_W-1:0] y);
        return (y > x) ? '0 : x - y;
    endfunction

    function automatic void retotal(int n);
        logic [SUM_W-1:0] t;
        t = '0;
        for (int i = 0; i < n; i++) t = clamp_add(t, row_q[i]);
        total_q = t;
    endfunction

    // bound times pair count, exact in 64 bits
    function automatic logic [SUM_W-1:0] cross_term(int i, int j);
        logic [SUM_W-1:0] cnt;
        cnt = SUM_W'(pop_q[i]) * SUM_W'(pop_q[j]);
        return SUM_W'(bound_q[i][j]) * cnt;
    endfunction

    function automatic void rebuild_rows(int n);
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] p;
        for (int i = 0; i < NBINS; i++) begin
            s = '0;
            p = SUM_W'(pop_q[i]);
            if (i < n) begin
                for (int j = 0; j < i; j++) s = clamp_add(s, cross_term(i, j));
                if (p != 0) s = clamp_add(s, SUM_W'(bound_q[i][i]) * ((p * (p - 1)) >> 1));
            end
            row_q[i] = s;
        end
        retotal(n);
    endfunction

    // one particle joins or leaves bin b; pop_q[b] holds the smaller count
    function automatic void shift_particle(int b, int n, bit grow);
        logic [SUM_W-1:0] d;
        logic [SUM_W-1:0] t;
        d = '0;
        for (int j = 0; j <= b; j++) d = d + SUM_W'(pop_q[j]) * SUM_W'(bound_q[b][j]);
        row_q[b] = grow ? clamp_add(row_q[b], d) : floor_sub(row_q[b], d);
        for (int j = b + 1; j < n; j++) begin
            t = SUM_W'(pop_q[j]) * SUM_W'(bound_q[b][j]);
            row_q[j] = grow ? clamp_add(row_q[j], t) : floor_sub(row_q[j], t);
        end
        retotal(n);
    endfunction

    function automatic t_rate_rsp apply_request(logic [CMD_W-1:0] cmd, logic [BIN_W-1:0] a,
                                                logic [BIN_W-1:0] b, logic [VAL_W-1:0] v);
        t_rate_rsp         e;
        int                n;
        int                i;
        int                j;
        logic [95:0]       prod;
        logic [SUM_W-1:0]  r;
        logic [SUM_W-1:0]  t;
        e = '0;
        n = bins_in_use();
        unique case (cmd)
            CMD_WR_BOUND: begin
                bound_q[a][b] = v;
                bound_q[b][a] = v;
            end
            CMD_SET_POP: pop_q[a] = v[POP_W-1:0];
            CMD_RECOMP:  rebuild_rows(n);
            CMD_ADD: begin
                if (a < n) begin
                    if (pop_q[a] == {POP_W{1'b1}}) begin
                        e.status = ST_OVF;
                    end else begin
                        shift_particle(a, n, 1'b1);
                        pop_q[a] = pop_q[a] + 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (a < n) begin
                    if (pop_q[a] == 0) begin
                        e.status = ST_UDF;
                    end else begin
                        pop_q[a] = pop_q[a] - 1'b1;
                        shift_particle(a, n, 1'b0);
                    end
                end
            end
            CMD_SELECT: begin
                if (total_q == 0) begin
                    e.status = ST_ZERO;
                end else begin
                    prod = 96'(total_q) * 96'(v);
                    r = prod[95:32];
                    i = n - 1;
                    while (i > 0 && r >= row_q[i]) begin
                        r = r - row_q[i];
                        i--;
                    end
                    j = 0;
                    while (j < i) begin
                        t = cross_term(i, j);
                        if (r < t) break;
                        r = r - t;
                        j++;
                    end
                    e.first_bin  = BIN_W'(i);
                    e.second_bin = BIN_W'(j);
                end
            end
            default: ;
        endcase
        e.total_rate = total_q;
        return e;
    endfunction

    // ---------------- request side ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // drive one request and wait for the accepting edge
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [BIN_W-1:0] a,
                                logic [BIN_W-1:0] b, logic [VAL_W-1:0] v,
                                bit typed, t_rate_rsp typed_rsp);
        int        gap;
        t_rate_rsp e;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.bin_a   <= a;
        req_if.bin_b   <= b;
        req_if.value   <= v;
        forever begin
            @(negedge i_clk);
            if (req_if.ready) break;
        end
        @(posedge i_clk);
        e = apply_request(cmd, a, b, v);
        pending_rsp.push_back(typed ? typed_rsp : e);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_active_bins(logic [CFG_W-1:0] x);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= x;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        bins_cfg = x;
    endtask

    function automatic logic [VAL_W-1:0] pick_bound();
        unique case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(0, 4));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_pop();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 12))};
        if (r < 14) return {16'($urandom), 16'hFFFF};
        if (r < 16) return {16'($urandom), 16'hFFFE};
        if (r < 17) return {16'($urandom), 16'h0000};
        return $urandom;
    endfunction

    // one random request; mostly particle traffic and selects on fresh sums
    task automatic random_request();
        int               r;
        int               n;
        logic [BIN_W-1:0] a;
        logic [BIN_W-1:0] b;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] v;
        n = bins_in_use();
        r = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) < 8) ? BIN_W'($urandom_range(0, n - 1)) : BIN_W'($urandom);
        b = BIN_W'($urandom);
        v = $urandom;
        if (r < 8) begin
            cmd = CMD_WR_BOUND;
            v = pick_bound();
        end else if (r < 25) begin
            cmd = CMD_SET_POP;
            v = pick_pop();
        end else if (r < 37) begin
            cmd = CMD_RECOMP;
        end else if (r < 55) begin
            cmd = CMD_ADD;
        end else if (r < 70) begin
            cmd = CMD_REMOVE;
        end else if (r < 97) begin
            cmd = CMD_SELECT;
            if ($urandom_range(0, 9) == 0) v = ($urandom_range(0, 1) == 1) ? '1 : '0;
        end else begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_SPARE6 : CMD_SPARE7;
        end
        send_request(cmd, a, b, v, 1'b0, '0);
    endtask

    // ---------------- result side ----------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
            stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // sample mid-cycle; the handshake completes at the following edge
    always @(negedge i_clk) begin
        t_rate_rsp e;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result fb=%0d sb=%0d total=%h st=%0d", $time,
                         rsp_if.first_bin, rsp_if.second_bin, rsp_if.total_rate,
                         rsp_if.status);
                err_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_if.first_bin !== e.first_bin) begin
                    $display("%0t: first_bin exp %0d got %0d", $time, e.first_bin,
                             rsp_if.first_bin);
                    err_cnt++;
                end
                if (rsp_if.second_bin !== e.second_bin) begin
                    $display("%0t: second_bin exp %0d got %0d", $time, e.second_bin,
                             rsp_if.second_bin);
                    err_cnt++;
                end
                if (rsp_if.total_rate !== e.total_rate) begin
                    $display("%0t: total_rate exp %h got %h", $time, e.total_rate,
                             rsp_if.total_rate);
                    err_cnt++;
                end
                if (rsp_if.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, rsp_if.status);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- directed table ----------------
    // Typed rows run right after the bound preload: rows and total are still zero and
    // only the population set in the table is not, so their results are obvious.
    localparam int DIR_N = 24;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    t_dir_row dir_tbl [DIR_N] = '{
        // empty total on select, both fractions
        '{CMD_SELECT,   4'd0,  4'd0,  32'h0000_0000, 1'b1, '{4'd0, 4'd0, 64'd0, ST_ZERO}},
        '{CMD_SELECT,   4'd0,  4'd0,  32'hFFFF_FFFF, 1'b1, '{4'd0, 4'd0, 64'd0, ST_ZERO}},
        // remove from an empty bin
        '{CMD_REMOVE,   4'd0,  4'd0,  32'h0000_0000, 1'b1, '{4'd0, 4'd0, 64'd0, ST_UDF}},
        // only the low half of value lands in the population
        '{CMD_SET_POP,  4'd15, 4'd9,  32'hABCD_FFFF, 1'b1, '{4'd0, 4'd0, 64'd0, ST_OK}},
        '{CMD_ADD,      4'd15, 4'd0,  32'h0000_0000, 1'b1, '{4'd0, 4'd0, 64'd0, ST_OVF}},
        '{CMD_SPARE6,   4'd3,  4'd7,  32'hFFFF_FFFF, 1'b1, '{4'd0, 4'd0, 64'd0, ST_OK}},
        '{CMD_SPARE7,   4'd15, 4'd15, 32'h1234_5678, 1'b1, '{4'd0, 4'd0, 64'd0, ST_OK}},
        // extreme bounds and populations, sums go stale until recompute
        '{CMD_WR_BOUND, 4'd15, 4'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_WR_BOUND, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_WR_BOUND, 4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_WR_BOUND, 4'd5,  4'd3,  32'h0001_0000, 1'b0, '0},
        '{CMD_SET_POP,  4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_SET_POP,  4'd3,  4'd0,  32'h0000_0002, 1'b0, '0},
        '{CMD_SET_POP,  4'd5,  4'd0,  32'h0000_0003, 1'b0, '0},
        // total saturates here
        '{CMD_RECOMP,   4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_SELECT,   4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_SELECT,   4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_SELECT,   4'd0,  4'd0,  32'h8000_0000, 1'b0, '0},
        '{CMD_SET_POP,  4'd15, 4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_RECOMP,   4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_ADD,      4'd3,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_REMOVE,   4'd5,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_REMOVE,   4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_SELECT,   4'd0,  4'd0,  32'h4000_0000, 1'b0, '0}
    };

    // active_bins per random phase: full, extremes, below and above range
    localparam int PHASES = 7;
    logic [CFG_W-1:0] phase_bins [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd12};

    initial begin
        req_if.valid   <= 1'b0;
        req_if.command <= CMD_WR_BOUND;
        req_if.bin_a   <= '0;
        req_if.bin_b   <= '0;
        req_if.value   <= '0;
        foreach (pop_q[i]) begin
            pop_q[i] = '0;
            row_q[i] = '0;
        end
        total_q  = '0;
        bins_cfg = CFG_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every bound gets written before anything can read it
        for (int i = 0; i < NBINS; i++) begin
            for (int j = 0; j <= i; j++) begin
                send_request(CMD_WR_BOUND, BIN_W'(i), BIN_W'(j), pick_bound(), 1'b0, '0);
            end
        end

        for (int k = 0; k < DIR_N; k++) begin
            send_request(dir_tbl[k].cmd, dir_tbl[k].a, dir_tbl[k].b, dir_tbl[k].val,
                         dir_tbl[k].typed, dir_tbl[k].rsp);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_active_bins(p == PHASES - 1 ? CFG_W'($urandom) : phase_bins[p]);
            calm = ($urandom_range(0, 3) == 0);
            // fresh sums for the new bin count, then traffic
            send_request(CMD_RECOMP, '0, '0, '0, 1'b0, '0);
            for (int k = 0; k < 48; k++) random_request();
        end
        calm = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
